// ----- rtl/crmt_pkg.sv -----
// Shared types, constants and saturating arithmetic for the lazy segment tree.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crmt_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VAL_W            = 48;
    localparam int CNT_REG_W        = 11;
    localparam int IDX_FIELD_W      = 10;
    localparam int OPND_W           = 32;
    localparam int CMD_W            = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] min_val;
        logic signed [VAL_W-1:0] pend;
    } node_word_t;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = (VAL_W+1)'(a) + (VAL_W+1)'(b);
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/crmt_node_ram.sv -----
// Node storage: minimum and pending add per tree node, one write and one read port.
// Depends on crmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crmt_node_ram #(
    parameter int MAX_ELEMENTS = crmt_pkg::MAX_ELEMENTS_DEF
) (
    input  wire                              aclk,
    input  wire                              we_i,
    input  wire [$clog2(MAX_ELEMENTS):0]     waddr_i,
    input  crmt_pkg::node_word_t             wdata_i,
    input  wire [$clog2(MAX_ELEMENTS):0]     raddr_i,
    output crmt_pkg::node_word_t             rdata_o
);
    import crmt_pkg::*;

    localparam int DEPTH = 2 << $clog2(MAX_ELEMENTS);

    node_word_t mem [DEPTH];
    node_word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[waddr_i] <= wdata_i;
        end
        rdata_reg <= mem[raddr_i];
    end

    assign rdata_o = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/crmt_ctrl.sv -----
// Tree walk sequencer: depth-first visit with push-down and pull-up through the node RAM.
// Depends on crmt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crmt_ctrl #(
    parameter int MAX_ELEMENTS = crmt_pkg::MAX_ELEMENTS_DEF
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       start_i,
    input  wire [crmt_pkg::CMD_W-1:0]                 command_i,
    input  wire [crmt_pkg::IDX_FIELD_W-1:0]           left_i,
    input  wire [crmt_pkg::IDX_FIELD_W-1:0]           right_i,
    input  wire signed [crmt_pkg::OPND_W-1:0]         operand_i,
    input  wire [crmt_pkg::CNT_REG_W-1:0]             count_i,
    output logic                                      ready_o,
    output logic                                      res_valid_o,
    input  wire                                       res_ready_i,
    output logic signed [crmt_pkg::VAL_W-1:0]         res_data_o,
    output logic                                      mem_we_o,
    output logic [$clog2(MAX_ELEMENTS):0]             mem_waddr_o,
    output crmt_pkg::node_word_t                      mem_wdata_o,
    output logic [$clog2(MAX_ELEMENTS):0]             mem_raddr_o,
    input  crmt_pkg::node_word_t                      mem_rdata_i
);
    import crmt_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int NODE_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int WIDE_W = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
    localparam int STK_W  = $clog2(IDX_W + 1);
    localparam int STK_D  = 1 << STK_W;
    localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_ELEMENTS);
    localparam logic [WIDE_W-1:0] ONE_WIDE = WIDE_W'(1);
    localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_ENTER   = 4'd2;
    localparam logic [3:0] ST_COVER   = 4'd3;
    localparam logic [3:0] ST_PUSH_RD = 4'd4;
    localparam logic [3:0] ST_PUSH_L  = 4'd5;
    localparam logic [3:0] ST_PUSH_R  = 4'd6;
    localparam logic [3:0] ST_PUSH_U  = 4'd7;
    localparam logic [3:0] ST_RETURN  = 4'd8;
    localparam logic [3:0] ST_PULL_A  = 4'd9;
    localparam logic [3:0] ST_PULL_B  = 4'd10;
    localparam logic [3:0] ST_RESULT  = 4'd11;

    logic [3:0]              state_reg, state_next;
    logic [NODE_W-1:0]       clr_reg, clr_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0]        l_reg, l_next;
    logic [IDX_W-1:0]        r_reg, r_next;
    logic                    wrap_reg, wrap_next;
    logic [IDX_W-1:0]        wrap_r_reg, wrap_r_next;
    logic [IDX_W-1:0]        last_reg, last_next;
    logic [NODE_W-1:0]       u_reg, u_next;
    logic [IDX_W-1:0]        lo_reg, lo_next;
    logic [IDX_W-1:0]        hi_reg, hi_next;
    logic [STK_W:0]          sp_reg, sp_next;
    logic signed [VAL_W-1:0] p_reg, p_next;
    logic signed [VAL_W-1:0] m_reg, m_next;
    logic signed [VAL_W-1:0] a_reg, a_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;

    logic [IDX_W-1:0] stk_lo [STK_D];
    logic [IDX_W-1:0] stk_hi [STK_D];
    logic             stk_push;

    logic [WIDE_W-1:0] cnt_w, last_w, l_w, r_w, lc_w, rc_w;
    logic [IDX_W:0]    mid_sum, pmid_sum;
    logic [IDX_W-1:0]  mid, plo, phi, pmid;
    logic [STK_W:0]    top;
    logic              covered;
    logic [NODE_W-1:0] child_l, child_r;
    logic signed [VAL_W-1:0] pull_min;

    assign cnt_w  = (count_i == '0) ? ONE_WIDE
                  : ((WIDE_W'(count_i) > MAX_WIDE) ? MAX_WIDE : WIDE_W'(count_i));
    assign last_w = cnt_w - ONE_WIDE;
    assign l_w    = WIDE_W'(left_i);
    assign r_w    = WIDE_W'(right_i);
    assign lc_w   = (l_w > last_w) ? last_w : l_w;
    assign rc_w   = (r_w > last_w) ? last_w : r_w;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IDX_W:1];
    assign top      = sp_reg - 1'b1;
    assign plo      = stk_lo[top[STK_W-1:0]];
    assign phi      = stk_hi[top[STK_W-1:0]];
    assign pmid_sum = {1'b0, plo} + {1'b0, phi};
    assign pmid     = pmid_sum[IDX_W:1];
    assign covered  = (lo_reg >= l_reg) && (hi_reg <= r_reg);
    assign child_l  = {u_reg[NODE_W-2:0], 1'b0};
    assign child_r  = {u_reg[NODE_W-2:0], 1'b1};
    assign pull_min = (a_reg < mem_rdata_i.min_val) ? a_reg : mem_rdata_i.min_val;

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        wrap_next   = wrap_reg;
        wrap_r_next = wrap_r_reg;
        last_next   = last_reg;
        u_next      = u_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sp_next     = sp_reg;
        p_next      = p_reg;
        m_next      = m_reg;
        a_next      = a_reg;
        acc_next    = acc_reg;
        stk_push    = 1'b0;
        mem_we_o    = 1'b0;
        mem_waddr_o = u_reg;
        mem_wdata_o = '{min_val: m_reg, pend: '0};
        mem_raddr_o = u_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = clr_reg;
                mem_wdata_o = '{min_val: '0, pend: '0};
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start_i) begin
                    cmd_next  = command_i;
                    val_next  = VAL_W'(operand_i);
                    last_next = last_w[IDX_W-1:0];
                    u_next    = ROOT;
                    lo_next   = '0;
                    hi_next   = last_w[IDX_W-1:0];
                    sp_next   = '0;
                    acc_next  = VAL_MAX;
                    wrap_next = 1'b0;
                    priority if (command_i == CMD_LOAD) begin
                        l_next = l_w[IDX_W-1:0];
                        r_next = l_w[IDX_W-1:0];
                        if (l_w < cnt_w) begin
                            state_next = ST_ENTER;
                        end
                    end else if (command_i == CMD_ADD || command_i == CMD_QUERY) begin
                        l_next      = lc_w[IDX_W-1:0];
                        wrap_r_next = rc_w[IDX_W-1:0];
                        if (lc_w <= rc_w) begin
                            r_next = rc_w[IDX_W-1:0];
                        end else begin
                            r_next    = last_w[IDX_W-1:0];
                            wrap_next = 1'b1;
                        end
                        state_next = ST_ENTER;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ENTER: begin
                mem_raddr_o = u_reg;
                state_next  = covered ? ST_COVER : ST_PUSH_RD;
            end
            ST_COVER: begin
                unique case (cmd_reg)
                    CMD_LOAD: begin
                        mem_we_o    = 1'b1;
                        mem_wdata_o = '{min_val: val_reg, pend: '0};
                    end
                    CMD_ADD: begin
                        mem_we_o    = 1'b1;
                        mem_wdata_o = '{min_val: sat_add(mem_rdata_i.min_val, val_reg),
                                        pend: sat_add(mem_rdata_i.pend, val_reg)};
                    end
                    default: begin
                        if (mem_rdata_i.min_val < acc_reg) begin
                            acc_next = mem_rdata_i.min_val;
                        end
                    end
                endcase
                state_next = ST_RETURN;
            end
            ST_PUSH_RD: begin
                p_next      = mem_rdata_i.pend;
                m_next      = mem_rdata_i.min_val;
                mem_raddr_o = child_l;
                state_next  = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = child_l;
                mem_wdata_o = '{min_val: sat_add(mem_rdata_i.min_val, p_reg),
                                pend: sat_add(mem_rdata_i.pend, p_reg)};
                mem_raddr_o = child_r;
                state_next  = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = child_r;
                mem_wdata_o = '{min_val: sat_add(mem_rdata_i.min_val, p_reg),
                                pend: sat_add(mem_rdata_i.pend, p_reg)};
                state_next  = ST_PUSH_U;
            end
            ST_PUSH_U: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = u_reg;
                mem_wdata_o = '{min_val: m_reg, pend: '0};
                stk_push    = 1'b1;
                sp_next     = sp_reg + 1'b1;
                if (l_reg <= mid) begin
                    u_next  = child_l;
                    hi_next = mid;
                end else begin
                    u_next  = child_r;
                    lo_next = mid + 1'b1;
                end
                state_next = ST_ENTER;
            end
            ST_RETURN: begin
                if (sp_reg == '0) begin
                    priority if (wrap_reg) begin
                        wrap_next  = 1'b0;
                        l_next     = '0;
                        r_next     = wrap_r_reg;
                        u_next     = ROOT;
                        lo_next    = '0;
                        hi_next    = last_reg;
                        state_next = ST_ENTER;
                    end else if (cmd_reg == CMD_QUERY) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (!u_reg[0] && (r_reg > pmid)) begin
                    u_next     = {u_reg[NODE_W-1:1], 1'b1};
                    lo_next    = pmid + 1'b1;
                    hi_next    = phi;
                    state_next = ST_ENTER;
                end else begin
                    sp_next     = top;
                    u_next      = {1'b0, u_reg[NODE_W-1:1]};
                    lo_next     = plo;
                    hi_next     = phi;
                    mem_raddr_o = {u_reg[NODE_W-1:1], 1'b0};
                    state_next  = (cmd_reg == CMD_QUERY) ? ST_RETURN : ST_PULL_A;
                end
            end
            ST_PULL_A: begin
                a_next      = mem_rdata_i.min_val;
                mem_raddr_o = child_r;
                state_next  = ST_PULL_B;
            end
            ST_PULL_B: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = u_reg;
                mem_wdata_o = '{min_val: pull_min, pend: '0};
                state_next  = ST_RETURN;
            end
            ST_RESULT: begin
                if (res_ready_i) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            wrap_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            wrap_reg  <= wrap_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        wrap_r_reg <= wrap_r_next;
        last_reg   <= last_next;
        u_reg      <= u_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        p_reg      <= p_next;
        m_reg      <= m_next;
        a_reg      <= a_next;
        acc_reg    <= acc_next;
        if (stk_push) begin
            stk_lo[sp_reg[STK_W-1:0]] <= lo_reg;
            stk_hi[sp_reg[STK_W-1:0]] <= hi_reg;
        end
    end

    assign ready_o     = (state_reg == ST_IDLE);
    assign res_valid_o = (state_reg == ST_RESULT);
    assign res_data_o  = acc_reg;

endmodule
`default_nettype wire

// ----- rtl/circular_range_add_range_min_tree.sv -----
// Operation: a load walks one root-to-leaf path; an add or query visits each fully covered
// node and each split node, pushing pending adds down at each split, and walks a wrapped
// range twice; loads and adds pull minima up. Node RAM: single-read, single-write port.
// Throughput: one command at a time; a finished minimum waits in the output register.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the node RAM, all
// 2*2^ceil(log2 MAX_ELEMENTS) words (2048 by default), before s_tready rises.
`timescale 1ns / 1ps
`default_nettype none
module circular_range_add_range_min_tree #(
    parameter int MAX_ELEMENTS = crmt_pkg::MAX_ELEMENTS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire [crmt_pkg::CNT_REG_W-1:0]      cfg_wr_data,   // element_count
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [55:0]                         s_tdata,       // command[1:0], left_index[11:2],
                                                              // right_index[21:12],
                                                              // operand_value[53:22]
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [47:0]                        m_tdata        // range_minimum[47:0]
);
    import crmt_pkg::*;

    localparam int NODE_W = $clog2(MAX_ELEMENTS) + 1;

    logic [CNT_REG_W-1:0]    count_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]        m_tdata_reg;
    logic                    ctrl_ready, res_valid, res_ready;
    logic signed [VAL_W-1:0] res_data;
    logic                    mem_we;
    logic [NODE_W-1:0]       mem_waddr, mem_raddr;
    node_word_t              mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_REG_W'(1);
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    assign s_tready  = ctrl_ready;
    assign res_ready = !m_tvalid_reg || m_tready;

    crmt_ctrl #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_i     (s_tvalid && ctrl_ready),
        .command_i   (s_tdata[1:0]),
        .left_i      (s_tdata[11:2]),
        .right_i     (s_tdata[21:12]),
        .operand_i   ($signed(s_tdata[53:22])),
        .count_i     (count_reg),
        .ready_o     (ctrl_ready),
        .res_valid_o (res_valid),
        .res_ready_i (res_ready),
        .res_data_o  (res_data),
        .mem_we_o    (mem_we),
        .mem_waddr_o (mem_waddr),
        .mem_wdata_o (mem_wdata),
        .mem_raddr_o (mem_raddr),
        .mem_rdata_i (mem_rdata)
    );

    crmt_node_ram #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_ram (
        .aclk    (aclk),
        .we_i    (mem_we),
        .waddr_i (mem_waddr),
        .wdata_i (mem_wdata),
        .raddr_i (mem_raddr),
        .rdata_o (mem_rdata)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= res_data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
